### src/mfdu_pkg.sv
// ----------------------------------------------------------------------------
// mfdu_pkg
// Shared types and constants for the motor feedback decode and unwrap block.
// ----------------------------------------------------------------------------
package mfdu_pkg;

  localparam int unsigned MFDU_ENCODER_COUNTS = 8192;

  localparam int unsigned ERR_W  = 18;
  localparam int unsigned MUL_AW = 33;
  localparam int unsigned MUL_BW = 18;
  localparam int unsigned PROD_W = MUL_AW + MUL_BW;
  localparam int unsigned ACC_W  = 60;
  localparam int unsigned DIFF_W = 41;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [31:0] ANGLE_GAIN_RST   = 32'd737280;
  localparam logic [31:0] SPEED_GAIN_RST   = 32'd100663296;
  localparam logic [31:0] CURRENT_GAIN_RST = 32'd4096;
  localparam logic [16:0] ALPHA_ONE        = 17'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REVERSE      = 3'd0,
    REG_ANGLE_GAIN   = 3'd1,
    REG_SPEED_GAIN   = 3'd2,
    REG_CURRENT_GAIN = 3'd3,
    REG_FILTER_ALPHA = 3'd4,
    REG_START_COUNT  = 3'd5
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ANG,
    ST_SPD,
    ST_CUR,
    ST_DIFF,
    ST_FHI,
    ST_FLO,
    ST_FACC,
    ST_FUPD,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    SEL_ANGLE,
    SEL_SPEED,
    SEL_CURRENT,
    SEL_FILT_HI,
    SEL_FILT_LO
  } mul_sel_t;

  typedef struct packed {
    logic     in_ready;
    logic     load_in;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     upd_angle;
    logic     upd_speed;
    logic     upd_current;
    logic     upd_diff;
    logic     acc_hi;
    logic     acc_lo;
    logic     upd_filt;
    logic     out_load;
  } ctrl_t;

  typedef struct packed {
    logic               mode;
    logic [15:0]        encoder_count;
    logic signed [15:0] speed_raw;
    logic signed [15:0] current_raw;
    logic [7:0]         temp_raw;
  } in_t;

  typedef struct packed {
    logic signed [47:0] angle_total;
    logic signed [39:0] speed_now;
    logic signed [39:0] speed_smooth;
    logic signed [31:0] current_now;
    logic [7:0]         temperature;
    logic               link_valid;
  } out_t;

endpackage

### src/motor_feedback_decode_unwrap.sv
// A feedback beat is stepped by the sequencer feeding five products through the single
// 33x18 multiplier; a link-lost beat goes straight to the last step. A new beat is taken
// only in the idle state, after the previous result has gone into the output register.
// A waiting result holds the block in its last step until taken.
// Reset (rst_n low, synchronous): gains to defaults, angle, speeds, current,
// temperature and link flag to zero, previous count to zero.
// ----------------------------------------------------------------------------
// motor_feedback_decode_unwrap
// Encoder unwrap into a multi-turn angle, scaled speed and current, low-pass speed.
// ----------------------------------------------------------------------------
module motor_feedback_decode_unwrap
  import mfdu_pkg::*;
#(
  parameter int unsigned ENCODER_COUNTS = MFDU_ENCODER_COUNTS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic signed [ERR_W-1:0] N_S    = ERR_W'(ENCODER_COUNTS);
  localparam logic signed [ERR_W-1:0] HALF_S = ERR_W'(ENCODER_COUNTS / 2);

  function automatic logic signed [47:0] sat48(input logic signed [48:0] x);
    if (x[48] == x[47]) begin
      return x[47:0];
    end
    return x[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
  endfunction

  function automatic logic signed [39:0] sat40(input logic signed [44:0] x);
    if ((&x[44:39]) || !(|x[44:39])) begin
      return x[39:0];
    end
    return x[44] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [44:0] x);
    if ((&x[44:31]) || !(|x[44:31])) begin
      return x[31:0];
    end
    return x[44] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
  endfunction

  ctrl_t ctrl;

  logic        reverse_r;
  logic [31:0] angle_gain_r;
  logic [31:0] speed_gain_r;
  logic [31:0] current_gain_r;
  logic [16:0] filter_alpha_r;
  logic [15:0] prev_count_r;

  logic signed [47:0] angle_sum_r;
  logic signed [39:0] speed_r;
  logic signed [39:0] filt_r;
  logic signed [31:0] cur_r;
  logic [7:0]         temp_r;
  logic               valid_r;

  logic signed [ERR_W-1:0]  err_r;
  logic signed [15:0]       spd_in_r;
  logic signed [15:0]       cur_in_r;
  logic signed [DIFF_W-1:0] diff_r;
  logic signed [ACC_W-1:0]  acc_r;

  logic               out_valid_r;
  out_t               out_data_r;

  logic signed [ERR_W-1:0]  err_raw;
  logic signed [ERR_W-1:0]  err_fold;
  logic [15:0]              d16;
  logic [16:0]              alpha_eff;
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] rnd8;
  logic signed [44:0]       rnd8_45;
  logic signed [44:0]       delta;
  logic signed [48:0]       angle_sum_w;
  logic signed [39:0]       spd_pos;
  logic signed [39:0]       spd_fin;
  logic signed [31:0]       cur_pos;
  logic signed [31:0]       cur_fin;
  logic signed [ACC_W-1:0]  rnd16;
  logic signed [44:0]       filt_sum;
  logic                     out_free;

  // encoder delta folded onto the shortest path
  always_comb begin
    d16     = in_data.encoder_count - prev_count_r;
    err_raw = ERR_W'($signed(d16));
    if (err_raw > HALF_S) begin
      err_fold = err_raw - N_S;
    end else if (err_raw < -HALF_S) begin
      err_fold = err_raw + N_S;
    end else begin
      err_fold = err_raw;
    end
  end

  assign alpha_eff = (filter_alpha_r > ALPHA_ONE) ? ALPHA_ONE : filter_alpha_r;

  always_comb begin
    case (ctrl.mul_sel)
      SEL_ANGLE: begin
        mul_a = $signed({1'b0, angle_gain_r});
        mul_b = err_r;
      end
      SEL_SPEED: begin
        mul_a = $signed({1'b0, speed_gain_r});
        mul_b = MUL_BW'(spd_in_r);
      end
      SEL_CURRENT: begin
        mul_a = $signed({1'b0, current_gain_r});
        mul_b = MUL_BW'(cur_in_r);
      end
      SEL_FILT_HI: begin
        mul_a = MUL_AW'($signed(diff_r[40:32]));
        mul_b = $signed({1'b0, alpha_eff});
      end
      SEL_FILT_LO: begin
        mul_a = $signed({1'b0, diff_r[31:0]});
        mul_b = $signed({1'b0, alpha_eff});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  mfdu_mul u_mul (
    .clk  (clk),
    .en   (ctrl.mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  mfdu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_data.mode),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  // Q.24 product to Q.16, round half up
  assign rnd8    = (prod + PROD_W'(128)) >>> 8;
  assign rnd8_45 = rnd8[44:0];

  assign delta       = reverse_r ? -rnd8_45 : rnd8_45;
  assign angle_sum_w = 49'(angle_sum_r) + 49'(delta);

  assign spd_pos = sat40(rnd8_45);
  assign spd_fin = reverse_r ? sat40(-45'(spd_pos)) : spd_pos;
  assign cur_pos = sat32(rnd8_45);
  assign cur_fin = reverse_r ? sat32(-45'(cur_pos)) : cur_pos;

  assign rnd16    = (acc_r + ACC_W'(32768)) >>> 16;
  assign filt_sum = 45'(filt_r) + $signed(rnd16[44:0]);

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reverse_r      <= 1'b0;
      angle_gain_r   <= ANGLE_GAIN_RST;
      speed_gain_r   <= SPEED_GAIN_RST;
      current_gain_r <= CURRENT_GAIN_RST;
      filter_alpha_r <= '0 | ALPHA_ONE;
      prev_count_r   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_REVERSE:      reverse_r      <= cfg_data[0];
          REG_ANGLE_GAIN:   angle_gain_r   <= cfg_data;
          REG_SPEED_GAIN:   speed_gain_r   <= cfg_data;
          REG_CURRENT_GAIN: current_gain_r <= cfg_data;
          REG_FILTER_ALPHA: filter_alpha_r <= {1'b0, cfg_data[15:0]} | {cfg_data[16], 16'd0};
          REG_START_COUNT:  prev_count_r   <= cfg_data[15:0];
          default: begin
          end
        endcase
      end
      if (ctrl.load_in && !in_data.mode) begin
        prev_count_r <= in_data.encoder_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_sum_r <= '0;
      speed_r     <= '0;
      filt_r      <= '0;
      cur_r       <= '0;
      temp_r      <= '0;
      valid_r     <= 1'b0;
    end else begin
      if (ctrl.load_in) begin
        valid_r <= !in_data.mode;
        if (!in_data.mode) begin
          temp_r <= in_data.temp_raw;
        end
      end
      if (ctrl.upd_angle) begin
        angle_sum_r <= sat48(angle_sum_w);
      end
      if (ctrl.upd_speed) begin
        speed_r <= spd_fin;
      end
      if (ctrl.upd_current) begin
        cur_r <= cur_fin;
      end
      if (ctrl.upd_filt) begin
        filt_r <= sat40(filt_sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      err_r    <= err_fold;
      spd_in_r <= in_data.speed_raw;
      cur_in_r <= in_data.current_raw;
    end
    if (ctrl.upd_diff) begin
      diff_r <= DIFF_W'(speed_r) - DIFF_W'(filt_r);
    end
    if (ctrl.acc_hi) begin
      acc_r <= $signed({prod[27:0], 32'd0});
    end else if (ctrl.acc_lo) begin
      acc_r <= acc_r + ACC_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_data_r.angle_total  <= angle_sum_r;
      out_data_r.speed_now    <= speed_r;
      out_data_r.speed_smooth <= filt_r;
      out_data_r.current_now  <= cur_r;
      out_data_r.temperature  <= temp_r;
      out_data_r.link_valid   <= valid_r;
    end
  end

  assign in_ready  = ctrl.in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("block still ready after accepting a beat");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.out_load |-> (!out_valid_r || out_ready))
    else $error("result register overwritten while holding a result");

  a_link_lost_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.mode |=> !valid_r)
    else $error("link-lost beat left the valid flag set");

  a_unity_filter: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.upd_filt && (alpha_eff == ALPHA_ONE) |=> filt_r == speed_r)
    else $error("unity filter coefficient did not pass speed through");
`endif

endmodule

### src/mfdu_mul.sv
// ----------------------------------------------------------------------------
// mfdu_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module mfdu_mul
  import mfdu_pkg::*;
(
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [MUL_AW-1:0] a,
  input  logic signed [MUL_BW-1:0] b,
  output logic signed [PROD_W-1:0] prod
);

  logic signed [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= a * b;
    end
  end

  assign prod = prod_r;

endmodule

### src/mfdu_ctrl.sv
// ----------------------------------------------------------------------------
// mfdu_ctrl
// Sequencer stepping one feedback beat through the shared multiplier.
// ----------------------------------------------------------------------------
module mfdu_ctrl
  import mfdu_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  logic  in_mode,
  input  logic  out_free,
  output ctrl_t ctrl
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    ctrl.mul_sel = SEL_ANGLE;
    unique case (state_r)
      ST_IDLE: begin
        ctrl.in_ready = 1'b1;
        if (in_valid) begin
          ctrl.load_in = 1'b1;
          state_nxt = in_mode ? ST_DONE : ST_ANG;
        end
      end
      ST_ANG: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = SEL_ANGLE;
        state_nxt    = ST_SPD;
      end
      ST_SPD: begin
        ctrl.mul_en    = 1'b1;
        ctrl.mul_sel   = SEL_SPEED;
        ctrl.upd_angle = 1'b1;
        state_nxt      = ST_CUR;
      end
      ST_CUR: begin
        ctrl.mul_en    = 1'b1;
        ctrl.mul_sel   = SEL_CURRENT;
        ctrl.upd_speed = 1'b1;
        state_nxt      = ST_DIFF;
      end
      ST_DIFF: begin
        ctrl.upd_current = 1'b1;
        ctrl.upd_diff    = 1'b1;
        state_nxt        = ST_FHI;
      end
      ST_FHI: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = SEL_FILT_HI;
        state_nxt    = ST_FLO;
      end
      ST_FLO: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = SEL_FILT_LO;
        ctrl.acc_hi  = 1'b1;
        state_nxt    = ST_FACC;
      end
      ST_FACC: begin
        ctrl.acc_lo = 1'b1;
        state_nxt   = ST_FUPD;
      end
      ST_FUPD: begin
        ctrl.upd_filt = 1'b1;
        state_nxt     = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          ctrl.out_load = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
